// ===== src/sctc_pkg.sv =====
package sctc_pkg;

	// Width of the internal line and column counters; the ports carry 16 bits.
	localparam int POS_W = 16;
	localparam int OUT_POS_W = 16;

	// Depth of the result queue.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	// Character codes used by the classifier.
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_UE     = 8'h45;
	localparam logic [7:0] CH_LE     = 8'h65;

	// Item types.
	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_END  = 1'b1;

	typedef enum logic [3:0] {
		K_SPACE   = 4'd0,
		K_COMMENT = 4'd1,
		K_IDENT   = 4'd2,
		K_NUMBER  = 4'd3,
		K_QUOTE   = 4'd4,
		K_STRING  = 4'd5,
		K_OPER    = 4'd6,
		K_SEP     = 4'd7,
		K_UNKNOWN = 4'd8,
		K_EOF     = 4'd9
	} kind_t;

	typedef enum logic [3:0] {
		M_IDLE    = 4'd0,
		M_COMMENT = 4'd1,
		M_IDENT   = 4'd2,
		M_INT     = 4'd3,
		M_FRAC    = 4'd4,
		M_EXP     = 4'd5,
		M_EXPDIG  = 4'd6,
		M_STRING  = 4'd7,
		M_OPFIRST = 4'd8
	} mode_t;

	// One result item.
	typedef struct packed {
		logic [7:0]           out_byte;
		kind_t                kind;
		logic                 starts_token;
		logic [OUT_POS_W-1:0] line_number;
		logic [OUT_POS_W-1:0] column_number;
		logic                 is_last;
	} item_t;

	// Outcome of classifying one byte.
	typedef struct packed {
		kind_t kind;
		logic  start;
		mode_t mode;
		logic  load_quote;
		logic  load_first;
	} cls_t;

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= CH_UA && b <= CH_UZ) || (b >= CH_LA && b <= CH_LZ) || b == CH_UNDER;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= CH_0 && b <= CH_9;
	endfunction

	function automatic logic is_exp_mark(input logic [7:0] b);
		return b == CH_LE || b == CH_UE || b == CH_CARET;
	endfunction

	function automatic logic pairs(input logic [7:0] f, input logic [7:0] b);
		if (b == CH_EQ)
			return f == CH_EQ || f == CH_BANG || f == CH_LT || f == CH_GT;
		return (f == CH_AMP && b == CH_AMP) || (f == CH_BAR && b == CH_BAR);
	endfunction

	// Label a byte that begins fresh, between tokens.
	function automatic cls_t fresh(input logic [7:0] b, input logic la_valid,
		input logic [7:0] la);
		cls_t r;
		r = '{kind: K_UNKNOWN, start: 1'b1, mode: M_IDLE, load_quote: 1'b0,
			load_first: 1'b0};
		if (b == CH_SPACE || b == CH_CR || b == CH_TAB || b == CH_LF) begin
			r.kind = K_SPACE;
			r.start = 1'b0;
		end else if (b == CH_SLASH && la_valid && la == CH_SLASH) begin
			r.kind = K_COMMENT;
			r.start = 1'b0;
			r.mode = M_COMMENT;
		end else if (is_letter(b)) begin
			r.kind = K_IDENT;
			r.mode = M_IDENT;
		end else if (is_digit(b)) begin
			r.kind = K_NUMBER;
			r.mode = M_INT;
		end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
			r.kind = K_QUOTE;
			r.mode = M_STRING;
			r.load_quote = 1'b1;
		end else if (b == CH_EQ || b == CH_BANG || b == CH_AMP || b == CH_BAR ||
			b == CH_LT || b == CH_GT) begin
			r.kind = K_OPER;
			r.mode = M_OPFIRST;
			r.load_first = 1'b1;
		end else if (b == CH_PLUS || b == CH_MINUS || b == CH_STAR || b == CH_SLASH ||
			b == CH_PCT) begin
			r.kind = K_OPER;
		end else if (b == CH_LPAR || b == CH_RPAR || b == CH_LBRACE || b == CH_RBRACE ||
			b == CH_COMMA || b == CH_SEMI || b == CH_COLON || b == CH_DOT) begin
			r.kind = K_SEP;
		end
		return r;
	endfunction

	// Continue the current token if the byte fits it, else label it fresh.
	function automatic cls_t classify(input mode_t mode, input logic [7:0] quote_char,
		input logic [7:0] first_op, input logic [7:0] b, input logic la_valid,
		input logic [7:0] la);
		cls_t r;
		r = fresh(b, la_valid, la);
		case (mode)
			M_COMMENT: begin
				if (b != CH_LF)
					r = '{kind: K_COMMENT, start: 1'b0, mode: M_COMMENT,
						load_quote: 1'b0, load_first: 1'b0};
			end
			M_IDENT: begin
				if (is_letter(b) || is_digit(b))
					r = '{kind: K_IDENT, start: 1'b0, mode: M_IDENT,
						load_quote: 1'b0, load_first: 1'b0};
			end
			M_INT: begin
				if (is_digit(b))
					r = '{kind: K_NUMBER, start: 1'b0, mode: M_INT,
						load_quote: 1'b0, load_first: 1'b0};
				else if (b == CH_DOT || b == CH_COMMA)
					r = '{kind: K_NUMBER, start: 1'b0, mode: M_FRAC,
						load_quote: 1'b0, load_first: 1'b0};
				else if (is_exp_mark(b))
					r = '{kind: K_NUMBER, start: 1'b0, mode: M_EXP,
						load_quote: 1'b0, load_first: 1'b0};
			end
			M_FRAC: begin
				if (is_digit(b))
					r = '{kind: K_NUMBER, start: 1'b0, mode: M_FRAC,
						load_quote: 1'b0, load_first: 1'b0};
				else if (is_exp_mark(b))
					r = '{kind: K_NUMBER, start: 1'b0, mode: M_EXP,
						load_quote: 1'b0, load_first: 1'b0};
			end
			M_EXP: begin
				if (b == CH_PLUS || b == CH_MINUS || is_digit(b))
					r = '{kind: K_NUMBER, start: 1'b0, mode: M_EXPDIG,
						load_quote: 1'b0, load_first: 1'b0};
			end
			M_EXPDIG: begin
				if (is_digit(b))
					r = '{kind: K_NUMBER, start: 1'b0, mode: M_EXPDIG,
						load_quote: 1'b0, load_first: 1'b0};
			end
			M_STRING: begin
				if (b == quote_char)
					r = '{kind: K_QUOTE, start: 1'b0, mode: M_IDLE,
						load_quote: 1'b0, load_first: 1'b0};
				else
					r = '{kind: K_STRING, start: 1'b0, mode: M_STRING,
						load_quote: 1'b0, load_first: 1'b0};
			end
			M_OPFIRST: begin
				if (pairs(first_op, b))
					r = '{kind: K_OPER, start: 1'b0, mode: M_IDLE,
						load_quote: 1'b0, load_first: 1'b0};
			end
			default: begin
				r = fresh(b, la_valid, la);
			end
		endcase
		return r;
	endfunction

endpackage

// ===== src/source_char_token_classifier_unit.sv =====
// Source text tokenizer front end. Each accepted item is either a source byte
// (func 0) or the end of the text (func 1). A byte is labeled when the next
// item arrives, since a '/' needs one byte of lookahead, so a byte item gives
// the label of the previous byte and an end item gives the last byte's label
// followed by an end-of-file mark with is_last set; the scanner then starts
// over at line 1, column 1. An item is taken every clock cycle unless input
// stalls: it is registered, and a byte is classified as the next item leaves
// that register; its labels go into a four-entry result queue that is drained
// one item per cycle while out_ready is high. Input stalls only when that queue
// holds more than two results. Line and column counters saturate at 65535.
module source_char_token_classifier_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           func,
	input  logic [7:0]                     char_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     out_byte,
	output logic [3:0]                     kind,
	output logic                           starts_token,
	output logic [sctc_pkg::OUT_POS_W-1:0] line_number,
	output logic [sctc_pkg::OUT_POS_W-1:0] column_number,
	output logic                           is_last
);
	import sctc_pkg::*;

	logic       valid_s1;
	logic       func_s1;
	logic [7:0] byte_s1;
	logic       go;
	logic       room;
	logic       res_a_valid;
	logic       res_b_valid;
	item_t      res_a;
	item_t      res_b;
	item_t      head;

	assign go       = valid_s1 && room;
	assign in_ready = !valid_s1 || go;

	// Hold the accepted item until the core takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1 <= func;
			byte_s1 <= char_byte;
		end
	end

	sctc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go),
		.func        (func_s1),
		.char_byte   (byte_s1),
		.res_a_valid (res_a_valid),
		.res_a       (res_a),
		.res_b_valid (res_b_valid),
		.res_b       (res_b)
	);

	sctc_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_a      (res_a_valid),
		.item_a    (res_a),
		.wr_b      (res_b_valid),
		.item_b    (res_b),
		.pop       (out_ready),
		.not_empty (out_valid),
		.room      (room),
		.head      (head)
	);

	assign out_byte      = head.out_byte;
	assign kind          = head.kind;
	assign starts_token  = head.starts_token;
	assign line_number   = head.line_number;
	assign column_number = head.column_number;
	assign is_last       = head.is_last;

endmodule

// ===== src/sctc_core.sv =====
module sctc_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic             func,
	input  logic [7:0]       char_byte,
	output logic             res_a_valid,
	output sctc_pkg::item_t  res_a,
	output logic             res_b_valid,
	output sctc_pkg::item_t  res_b
);
	import sctc_pkg::*;

	mode_t            mode_q;
	logic [7:0]       pend_byte_q;
	logic             pend_valid_q;
	logic [POS_W-1:0] pend_line_q;
	logic [POS_W-1:0] pend_col_q;
	logic [POS_W-1:0] line_q;
	logic [POS_W-1:0] col_q;
	logic [7:0]       quote_q;
	logic [7:0]       first_op_q;

	cls_t  cls;
	item_t eof_item;
	item_t byte_item;

	// Label the held byte, looking ahead at the incoming byte.
	assign cls = classify(mode_q, quote_q, first_op_q, pend_byte_q,
		func == FUNC_BYTE, char_byte);

	always_comb begin
		byte_item = '{out_byte: pend_byte_q, kind: cls.kind, starts_token: cls.start,
			line_number: OUT_POS_W'(pend_line_q), column_number: OUT_POS_W'(pend_col_q),
			is_last: 1'b0};
		eof_item = '{out_byte: 8'h00, kind: K_EOF, starts_token: 1'b1,
			line_number: OUT_POS_W'(line_q), column_number: OUT_POS_W'(col_q),
			is_last: 1'b1};
	end

	// Order results: held byte first, then the end-of-file mark.
	always_comb begin
		res_a_valid = go && (pend_valid_q || func == FUNC_END);
		res_a       = pend_valid_q ? byte_item : eof_item;
		res_b_valid = go && pend_valid_q && func == FUNC_END;
		res_b       = eof_item;
	end

	// Advance the scanner state, or clear it after the end item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_IDLE;
			pend_byte_q  <= 8'h00;
			pend_valid_q <= 1'b0;
			pend_line_q  <= POS_W'(1);
			pend_col_q   <= POS_W'(1);
			line_q       <= POS_W'(1);
			col_q        <= POS_W'(1);
			quote_q      <= 8'h00;
			first_op_q   <= 8'h00;
		end else if (go) begin
			if (func == FUNC_END) begin
				mode_q       <= M_IDLE;
				pend_byte_q  <= 8'h00;
				pend_valid_q <= 1'b0;
				pend_line_q  <= POS_W'(1);
				pend_col_q   <= POS_W'(1);
				line_q       <= POS_W'(1);
				col_q        <= POS_W'(1);
				quote_q      <= 8'h00;
				first_op_q   <= 8'h00;
			end else begin
				if (pend_valid_q) begin
					mode_q <= cls.mode;
					if (cls.load_quote)
						quote_q <= pend_byte_q;
					if (cls.load_first)
						first_op_q <= pend_byte_q;
				end
				pend_byte_q  <= char_byte;
				pend_valid_q <= 1'b1;
				pend_line_q  <= line_q;
				pend_col_q   <= col_q;
				// Saturate the position counters.
				if (char_byte == CH_LF) begin
					if (line_q != {POS_W{1'b1}})
						line_q <= line_q + 1'b1;
					col_q <= POS_W'(1);
				end else if (col_q != {POS_W{1'b1}}) begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

endmodule

// ===== src/sctc_out_queue.sv =====
module sctc_out_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_a,
	input  sctc_pkg::item_t item_a,
	input  logic            wr_b,
	input  sctc_pkg::item_t item_b,
	input  logic            pop,
	output logic            not_empty,
	output logic            room,
	output sctc_pkg::item_t head
);
	import sctc_pkg::*;

	item_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_ptr_q;
	logic [QUEUE_AW-1:0]  rd_ptr_q;
	logic [QUEUE_AW:0]    cnt_q;
	logic [QUEUE_AW-1:0]  wr_next;
	logic [QUEUE_AW:0]    n_wr;
	logic                 do_pop;

	assign not_empty = cnt_q != '0;
	// Leave space for the two results an end item may bring.
	assign room      = cnt_q <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2);
	assign head      = mem_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;
	assign wr_next   = wr_ptr_q + 1'b1;
	assign n_wr      = (QUEUE_AW+1)'(wr_a) + (QUEUE_AW+1)'(wr_b);

	// Write up to two items, packed in order.
	always_ff @(posedge clk) begin
		if (wr_a)
			mem_q[wr_ptr_q] <= item_a;
		if (wr_b)
			mem_q[wr_a ? wr_next : wr_ptr_q] <= item_b;
	end

	// Track pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QUEUE_AW'(n_wr);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + n_wr - (QUEUE_AW+1)'(do_pop);
		end
	end

endmodule

// ===== src/sctc_checker.sv =====
module sctc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [7:0]                     out_byte,
	input logic [3:0]                     kind,
	input logic                           starts_token,
	input logic [sctc_pkg::OUT_POS_W-1:0] line_number,
	input logic [sctc_pkg::OUT_POS_W-1:0] column_number,
	input logic                           is_last
);
	import sctc_pkg::*;

	// The end-of-file mark and is_last always travel together.
	a_last_is_eof: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_last |-> kind == K_EOF && out_byte == 8'h00 && starts_token)
		else $error("is_last on an item that is not an end-of-file mark");

	a_eof_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == K_EOF |-> is_last)
		else $error("end-of-file mark without is_last");

	// Blanks and comment text never open a token.
	a_no_start_on_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == K_SPACE || kind == K_COMMENT) |-> !starts_token)
		else $error("space or comment byte flagged as token start");

	// Positions are one-based and never wrap to zero.
	a_position_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line_number != '0 && column_number != '0)
		else $error("zero line or column on a result item");

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind) &&
			$stable(line_number) && $stable(column_number))
		else $error("result changed while stalled");

endmodule

bind source_char_token_classifier_unit sctc_checker u_sctc_checker (.*);
